[hw/rtl/sincos_pkg.sv]
package sincos_pkg;

    // series length and derived counts
    localparam int SERIES_TERMS = 21;
    localparam int NUM_CELLS    = SERIES_TERMS - 1;

    // field widths
    localparam int ANGLE_W    = 32;
    localparam int ANGLE_FRAC = 28;
    localparam int VALUE_W    = 32;
    localparam int VALUE_FRAC = 30;
    localparam int TOL_W      = 21;

    // internal q8.40 widths
    localparam int FRAC_W    = 40;
    localparam int X_W       = ANGLE_W + FRAC_W - ANGLE_FRAC;
    localparam int XMAG_W    = X_W - 1;
    localparam int Y_W       = 2 * XMAG_W - FRAC_W;
    localparam int ACC_W     = 48;
    localparam int MAG_W     = ACC_W;
    localparam int OUT_SHIFT = FRAC_W - VALUE_FRAC;
    localparam int SMAG_W    = MAG_W - OUT_SHIFT;

    // constant divisors of the horner steps, replaced by reciprocals
    localparam int DMAX    = (2 * SERIES_TERMS - 2) * (2 * SERIES_TERMS - 1);
    localparam int DIV_W   = $clog2(DMAX);
    localparam int RECIP_K = MAG_W - 1 + DIV_W;
    localparam int RECIP_W = RECIP_K;
    localparam int QUO_W   = MAG_W - 1;

    localparam logic signed [X_W-1:0]   TWO_PI_Q40  = 44'sh6487ED5110B;
    localparam logic signed [ACC_W-1:0] ONE_Q40     = ACC_W'(64'd1 << FRAC_W);
    localparam logic [MAG_W-1:0]        MAG_CAP_NEG = MAG_W'(64'd1 << (MAG_W - 1));
    localparam logic [MAG_W-1:0]        MAG_CAP_POS = MAG_W'((64'd1 << (MAG_W - 1)) - 64'd1);
    localparam logic [SMAG_W-1:0]       OUT_ONE     = SMAG_W'(64'd1 << VALUE_FRAC);

    // function select
    localparam logic MODE_SIN = 1'b0;
    localparam logic MODE_COS = 1'b1;

    // register port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int REG_IDX_W = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_SNAP_TOL = '0;
    localparam logic [TOL_W-1:0] SNAP_TOL_RESET = 21'd1074;

    // one item in flight along the row of cells
    typedef struct packed {
        logic                    valid;
        logic                    mode;
        logic signed [X_W-1:0]   x;
        logic [Y_W-1:0]          y;
        logic signed [ACC_W-1:0] acc;
    } item_t;

endpackage

[hw/rtl/sincos_front.sv]
module sincos_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                adv,
    input  logic                                arg_valid,
    input  logic                                mode,
    input  logic signed [sincos_pkg::ANGLE_W-1:0] angle,
    output sincos_pkg::item_t                   item_out
);
    import sincos_pkg::*;

    localparam int XL_W  = XMAG_W / 2;
    localparam int XH_W  = XMAG_W - XL_W;
    localparam int SQ_W  = 2 * XMAG_W;

    typedef struct packed {
        logic                  valid;
        logic                  mode;
        logic signed [X_W-1:0] x;
    } red_t;

    typedef struct packed {
        logic                    valid;
        logic                    mode;
        logic signed [X_W-1:0]   x;
        logic [2*XL_W-1:0]       sq_ll;
        logic [XL_W+XH_W-1:0]    sq_lh;
        logic [2*XH_W-1:0]       sq_hh;
    } sq_t;

    red_t  red_reg, red_next;
    sq_t   sq_reg, sq_next;
    item_t item_reg, item_next;

    logic signed [X_W-1:0] x_scaled;
    logic [X_W-1:0]        x_bits;
    logic [XMAG_W-1:0]     x_mag;
    logic [XL_W-1:0]       x_lo;
    logic [XH_W-1:0]       x_hi;
    logic [SQ_W-1:0]       sq_sum;

    // q4.28 to q4.40, then one step of reduction toward zero
    always_comb
    begin
        x_scaled = $signed({angle, {(FRAC_W - ANGLE_FRAC){1'b0}}});
        red_next.valid = arg_valid;
        red_next.mode  = mode;
        priority if (x_scaled >= TWO_PI_Q40)
        begin
            red_next.x = x_scaled - TWO_PI_Q40;
        end
        else if (x_scaled <= -TWO_PI_Q40)
        begin
            red_next.x = x_scaled + TWO_PI_Q40;
        end
        else
        begin
            red_next.x = x_scaled;
        end
    end

    always_comb
    begin
        x_bits = red_reg.x;
        x_mag  = red_reg.x[X_W-1] ? XMAG_W'(~x_bits + X_W'(1)) : XMAG_W'(x_bits);
        x_lo   = x_mag[XL_W-1:0];
        x_hi   = x_mag[XMAG_W-1:XL_W];
        sq_next.valid = red_reg.valid;
        sq_next.mode  = red_reg.mode;
        sq_next.x     = red_reg.x;
        sq_next.sq_ll = (2*XL_W)'(x_lo) * (2*XL_W)'(x_lo);
        sq_next.sq_lh = (XL_W+XH_W)'(x_lo) * (XL_W+XH_W)'(x_hi);
        sq_next.sq_hh = (2*XH_W)'(x_hi) * (2*XH_W)'(x_hi);
    end

    // cross term appears twice, hence one extra bit of shift
    always_comb
    begin
        sq_sum = SQ_W'(sq_reg.sq_ll)
               + (SQ_W'(sq_reg.sq_lh) << (XL_W + 1))
               + (SQ_W'(sq_reg.sq_hh) << (2 * XL_W));
        item_next.valid = sq_reg.valid;
        item_next.mode  = sq_reg.mode;
        item_next.x     = sq_reg.x;
        item_next.y     = sq_sum[FRAC_W +: Y_W];
        item_next.acc   = ONE_Q40;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_reg  <= '0;
            sq_reg   <= '0;
            item_reg <= '0;
        end
        else if (adv)
        begin
            red_reg  <= red_next;
            sq_reg   <= sq_next;
            item_reg <= item_next;
        end
    end

    assign item_out = item_reg;

endmodule

[hw/rtl/sincos_cell.sv]
module sincos_cell (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                adv,
    input  logic [sincos_pkg::RECIP_W-1:0]      recip_sin,
    input  logic [sincos_pkg::RECIP_W-1:0]      recip_cos,
    input  sincos_pkg::item_t                   item_in,
    output sincos_pkg::item_t                   item_out
);
    import sincos_pkg::*;

    // one horner step: acc' = 1 - trunc(trunc(y * acc) / d)
    localparam int YL_W    = Y_W / 2;
    localparam int YH_W    = Y_W - YL_W;
    localparam int AL_W    = MAG_W / 2;
    localparam int AH_W    = MAG_W - AL_W;
    localparam int PROD_W  = Y_W + MAG_W;
    localparam int MFULL_W = PROD_W - FRAC_W;
    localparam int ML_W    = MAG_W / 2;
    localparam int MH_W    = MAG_W - ML_W;
    localparam int RL_W    = RECIP_W / 2;
    localparam int RH_W    = RECIP_W - RL_W;
    localparam int MR_W    = MAG_W + RECIP_W;

    typedef struct packed {
        logic                  valid;
        logic                  mode;
        logic signed [X_W-1:0] x;
        logic [Y_W-1:0]        y;
        logic                  neg;
        logic [YL_W+AL_W-1:0]  p_ll;
        logic [YL_W+AH_W-1:0]  p_lh;
        logic [YH_W+AL_W-1:0]  p_hl;
        logic [YH_W+AH_W-1:0]  p_hh;
    } mul_t;

    typedef struct packed {
        logic                  valid;
        logic                  mode;
        logic signed [X_W-1:0] x;
        logic [Y_W-1:0]        y;
        logic                  neg;
        logic [MAG_W-1:0]      m;
    } prod_t;

    typedef struct packed {
        logic                  valid;
        logic                  mode;
        logic signed [X_W-1:0] x;
        logic [Y_W-1:0]        y;
        logic                  neg;
        logic [ML_W+RL_W-1:0]  q_ll;
        logic [ML_W+RH_W-1:0]  q_lh;
        logic [MH_W+RL_W-1:0]  q_hl;
        logic [MH_W+RH_W-1:0]  q_hh;
    } div_t;

    mul_t  mul_reg, mul_next;
    prod_t prod_reg, prod_next;
    div_t  div_reg, div_next;
    item_t item_reg, item_next;

    logic [MAG_W-1:0]   acc_bits;
    logic [MAG_W-1:0]   a_mag;
    logic [PROD_W-1:0]  prod_sum;
    logic [MFULL_W-1:0] m_full;
    logic [MAG_W-1:0]   m_cap;
    logic [RECIP_W-1:0] recip;
    logic [MR_W-1:0]    mr_sum;
    logic [QUO_W-1:0]   quo;
    logic signed [ACC_W-1:0] quo_ext;

    always_comb
    begin
        acc_bits = item_in.acc;
        a_mag    = item_in.acc[ACC_W-1] ? (~acc_bits + MAG_W'(1)) : acc_bits;
        mul_next.valid = item_in.valid;
        mul_next.mode  = item_in.mode;
        mul_next.x     = item_in.x;
        mul_next.y     = item_in.y;
        mul_next.neg   = item_in.acc[ACC_W-1];
        mul_next.p_ll  = (YL_W+AL_W)'(item_in.y[YL_W-1:0]) * (YL_W+AL_W)'(a_mag[AL_W-1:0]);
        mul_next.p_lh  = (YL_W+AH_W)'(item_in.y[YL_W-1:0]) * (YL_W+AH_W)'(a_mag[MAG_W-1:AL_W]);
        mul_next.p_hl  = (YH_W+AL_W)'(item_in.y[Y_W-1:YL_W]) * (YH_W+AL_W)'(a_mag[AL_W-1:0]);
        mul_next.p_hh  = (YH_W+AH_W)'(item_in.y[Y_W-1:YL_W])
                       * (YH_W+AH_W)'(a_mag[MAG_W-1:AL_W]);
    end

    // product back to q8.40 and saturated, the cap depends on the sign
    always_comb
    begin
        prod_sum = PROD_W'(mul_reg.p_ll)
                 + (PROD_W'(mul_reg.p_lh) << AL_W)
                 + (PROD_W'(mul_reg.p_hl) << YL_W)
                 + (PROD_W'(mul_reg.p_hh) << (YL_W + AL_W));
        m_full   = prod_sum[PROD_W-1:FRAC_W];
        m_cap    = mul_reg.neg ? MAG_CAP_NEG : MAG_CAP_POS;
        prod_next.valid = mul_reg.valid;
        prod_next.mode  = mul_reg.mode;
        prod_next.x     = mul_reg.x;
        prod_next.y     = mul_reg.y;
        prod_next.neg   = mul_reg.neg;
        prod_next.m     = (m_full > MFULL_W'(m_cap)) ? m_cap : m_full[MAG_W-1:0];
    end

    always_comb
    begin
        recip = (prod_reg.mode == MODE_COS) ? recip_cos : recip_sin;
        div_next.valid = prod_reg.valid;
        div_next.mode  = prod_reg.mode;
        div_next.x     = prod_reg.x;
        div_next.y     = prod_reg.y;
        div_next.neg   = prod_reg.neg;
        div_next.q_ll  = (ML_W+RL_W)'(prod_reg.m[ML_W-1:0]) * (ML_W+RL_W)'(recip[RL_W-1:0]);
        div_next.q_lh  = (ML_W+RH_W)'(prod_reg.m[ML_W-1:0])
                       * (ML_W+RH_W)'(recip[RECIP_W-1:RL_W]);
        div_next.q_hl  = (MH_W+RL_W)'(prod_reg.m[MAG_W-1:ML_W])
                       * (MH_W+RL_W)'(recip[RL_W-1:0]);
        div_next.q_hh  = (MH_W+RH_W)'(prod_reg.m[MAG_W-1:ML_W])
                       * (MH_W+RH_W)'(recip[RECIP_W-1:RL_W]);
    end

    // quotient magnitude stays at most 2^46, so 1 -/+ q never leaves range
    always_comb
    begin
        mr_sum = MR_W'(div_reg.q_ll)
               + (MR_W'(div_reg.q_lh) << RL_W)
               + (MR_W'(div_reg.q_hl) << ML_W)
               + (MR_W'(div_reg.q_hh) << (ML_W + RL_W));
        quo     = mr_sum[RECIP_K +: QUO_W];
        quo_ext = $signed(ACC_W'(quo));
        item_next.valid = div_reg.valid;
        item_next.mode  = div_reg.mode;
        item_next.x     = div_reg.x;
        item_next.y     = div_reg.y;
        item_next.acc   = div_reg.neg ? (ONE_Q40 + quo_ext) : (ONE_Q40 - quo_ext);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_reg  <= '0;
            prod_reg <= '0;
            div_reg  <= '0;
            item_reg <= '0;
        end
        else if (adv)
        begin
            mul_reg  <= mul_next;
            prod_reg <= prod_next;
            div_reg  <= div_next;
            item_reg <= item_next;
        end
    end

    assign item_out = item_reg;

endmodule

[hw/rtl/sincos_back.sv]
module sincos_back (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  sincos_pkg::item_t                     item_in,
    input  logic [sincos_pkg::TOL_W-1:0]          snap_tol,
    output logic                                  adv,
    output logic                                  res_valid,
    input  logic                                  res_ready,
    output logic signed [sincos_pkg::VALUE_W-1:0] value
);
    import sincos_pkg::*;

    localparam int XL_W    = XMAG_W / 2;
    localparam int XH_W    = XMAG_W - XL_W;
    localparam int AL_W    = MAG_W / 2;
    localparam int AH_W    = MAG_W - AL_W;
    localparam int PROD_W  = XMAG_W + MAG_W;
    localparam int MFULL_W = PROD_W - FRAC_W;
    localparam int RMAG_W  = VALUE_W - 1;

    typedef struct packed {
        logic                  valid;
        logic                  mode;
        logic                  neg;
        logic                  acc_neg;
        logic [MAG_W-1:0]      a_mag;
        logic [XL_W+AL_W-1:0]  p_ll;
        logic [XL_W+AH_W-1:0]  p_lh;
        logic [XH_W+AL_W-1:0]  p_hl;
        logic [XH_W+AH_W-1:0]  p_hh;
    } mul_t;

    typedef struct packed {
        logic              valid;
        logic              sgn;
        logic [SMAG_W-1:0] smag;
    } sum_t;

    mul_t mul_reg, mul_next;
    sum_t sum_reg, sum_next;

    logic                      res_valid_reg, res_valid_next;
    logic [VALUE_W-1:0]        value_reg, value_next;

    logic [X_W-1:0]     x_bits;
    logic [XMAG_W-1:0]  x_mag;
    logic [MAG_W-1:0]   acc_bits;
    logic [MAG_W-1:0]   a_mag;
    logic [PROD_W-1:0]  prod_sum;
    logic [MFULL_W-1:0] m_full;
    logic [MAG_W-1:0]   m_cap;
    logic [MAG_W-1:0]   sum_mag;
    logic [SMAG_W-1:0]  tol;
    logic [SMAG_W-1:0]  dist_one;
    logic [RMAG_W-1:0]  res_mag;
    logic [VALUE_W-1:0] res_bits;
    logic               load;

    // the row stalls only when a second result would overrun the output register
    assign adv  = !(sum_reg.valid && res_valid_reg && !res_ready);
    assign load = sum_reg.valid && adv;

    // sine needs x * acc, cosine takes acc as it is
    always_comb
    begin
        x_bits   = item_in.x;
        x_mag    = item_in.x[X_W-1] ? XMAG_W'(~x_bits + X_W'(1)) : XMAG_W'(x_bits);
        acc_bits = item_in.acc;
        a_mag    = item_in.acc[ACC_W-1] ? (~acc_bits + MAG_W'(1)) : acc_bits;
        mul_next.valid   = item_in.valid;
        mul_next.mode    = item_in.mode;
        mul_next.neg     = item_in.x[X_W-1] ^ item_in.acc[ACC_W-1];
        mul_next.acc_neg = item_in.acc[ACC_W-1];
        mul_next.a_mag   = a_mag;
        mul_next.p_ll    = (XL_W+AL_W)'(x_mag[XL_W-1:0]) * (XL_W+AL_W)'(a_mag[AL_W-1:0]);
        mul_next.p_lh    = (XL_W+AH_W)'(x_mag[XL_W-1:0]) * (XL_W+AH_W)'(a_mag[MAG_W-1:AL_W]);
        mul_next.p_hl    = (XH_W+AL_W)'(x_mag[XMAG_W-1:XL_W]) * (XH_W+AL_W)'(a_mag[AL_W-1:0]);
        mul_next.p_hh    = (XH_W+AH_W)'(x_mag[XMAG_W-1:XL_W])
                         * (XH_W+AH_W)'(a_mag[MAG_W-1:AL_W]);
    end

    always_comb
    begin
        prod_sum = PROD_W'(mul_reg.p_ll)
                 + (PROD_W'(mul_reg.p_lh) << AL_W)
                 + (PROD_W'(mul_reg.p_hl) << XL_W)
                 + (PROD_W'(mul_reg.p_hh) << (XL_W + AL_W));
        m_full   = prod_sum[PROD_W-1:FRAC_W];
        m_cap    = mul_reg.neg ? MAG_CAP_NEG : MAG_CAP_POS;
        if (mul_reg.mode == MODE_COS)
        begin
            sum_mag      = mul_reg.a_mag;
            sum_next.sgn = mul_reg.acc_neg;
        end
        else
        begin
            sum_mag      = (m_full > MFULL_W'(m_cap)) ? m_cap : m_full[MAG_W-1:0];
            sum_next.sgn = mul_reg.neg;
        end
        sum_next.valid = mul_reg.valid;
        // truncation toward zero to q2.30 works on the magnitude
        sum_next.smag  = sum_mag[MAG_W-1:OUT_SHIFT];
    end

    // snap to zero first, then snap to one and saturation share the same result
    always_comb
    begin
        tol      = SMAG_W'(snap_tol);
        dist_one = (sum_reg.smag >= OUT_ONE) ? (sum_reg.smag - OUT_ONE)
                                             : (OUT_ONE - sum_reg.smag);
        priority if (sum_reg.smag < tol)
        begin
            res_mag = '0;
        end
        else if ((dist_one < tol) || (sum_reg.smag > OUT_ONE))
        begin
            res_mag = RMAG_W'(OUT_ONE);
        end
        else
        begin
            res_mag = RMAG_W'(sum_reg.smag);
        end
        res_bits   = {1'b0, res_mag};
        value_next = sum_reg.sgn ? (~res_bits + VALUE_W'(1)) : res_bits;
    end

    always_comb
    begin
        if (load)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_reg       <= '0;
            sum_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (adv)
            begin
                mul_reg <= mul_next;
                sum_reg <= sum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            value_reg <= value_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign value     = $signed(value_reg);

endmodule

[hw/rtl/sine_cosine_taylor_series_unit.sv]
// Sine or cosine of a signed q4.28 angle in radians, returned as signed q2.30 in [-1, +1].
// The angle is reduced modulo 2*pi keeping its sign, then the Taylor series is summed by
// Horner steps in x*x, one cell per step, in q8.40 with truncation; results within
// snap_tolerance output LSBs of 0 or of magnitude 1 are snapped. One item is taken every
// clock while the row is not halted. Each item passes the front stages, then the row of
// Horner cells, each four stages deep (two split multiplies, one by y and one by the step's
// divisor reciprocal), then the back stages. Items keep flowing while a result waits in
// the output register; the row halts only when the next result reaches it too.
// snap_tolerance sits at byte address 0 and may be written only while no item is in flight.
module sine_cosine_taylor_series_unit (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   arg_valid,
    output logic                                   arg_ready,
    input  logic                                   mode,
    input  logic signed [sincos_pkg::ANGLE_W-1:0]  angle,
    output logic                                   res_valid,
    input  logic                                   res_ready,
    output logic signed [sincos_pkg::VALUE_W-1:0]  value,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [sincos_pkg::PADDR_W-1:0]         paddr,
    input  logic [sincos_pkg::PDATA_W-1:0]         pwdata,
    output logic [sincos_pkg::PDATA_W-1:0]         prdata,
    output logic                                   pready
);
    import sincos_pkg::*;

    item_t chain [NUM_CELLS+1];
    logic  adv;

    logic [TOL_W-1:0] snap_tol_reg, snap_tol_next;
    logic             tol_sel;
    logic             tol_wr;

    assign tol_sel = (paddr[PADDR_W-1:2] == REG_SNAP_TOL);
    assign tol_wr  = psel && penable && pwrite && tol_sel;
    assign pready  = 1'b1;
    assign prdata  = tol_sel ? PDATA_W'(snap_tol_reg) : '0;

    assign snap_tol_next = tol_wr ? pwdata[TOL_W-1:0] : snap_tol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_tol_reg <= SNAP_TOL_RESET;
        end
        else
        begin
            snap_tol_reg <= snap_tol_next;
        end
    end

    assign arg_ready = adv;

    sincos_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .arg_valid (arg_valid),
        .mode      (mode),
        .angle     (angle),
        .item_out  (chain[0])
    );

    // first cell takes the innermost term of the series
    for (genvar g = 0; g < NUM_CELLS; g++)
    begin : g_cell
        localparam int TERM = NUM_CELLS - g;
        localparam logic [63:0] DIV_SIN = 64'((2 * TERM) * (2 * TERM + 1));
        localparam logic [63:0] DIV_COS = 64'((2 * TERM - 1) * (2 * TERM));
        localparam logic [RECIP_W-1:0] RECIP_SIN =
            RECIP_W'(((64'd1 << RECIP_K) + DIV_SIN - 64'd1) / DIV_SIN);
        localparam logic [RECIP_W-1:0] RECIP_COS =
            RECIP_W'(((64'd1 << RECIP_K) + DIV_COS - 64'd1) / DIV_COS);

        sincos_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .recip_sin (RECIP_SIN),
            .recip_cos (RECIP_COS),
            .item_in   (chain[g]),
            .item_out  (chain[g+1])
        );
    end

    sincos_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_in   (chain[NUM_CELLS]),
        .snap_tol  (snap_tol_reg),
        .adv       (adv),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .value     (value)
    );

endmodule

[tb/sine_cosine_taylor_series_unit_test.sv]
module sine_cosine_taylor_series_unit_test;
    import sincos_pkg::*;

    localparam int     TERMS        = SERIES_TERMS;
    localparam longint Q40_UNIT     = 64'sd1 << 40;
    localparam longint Q40_TOP      = (64'sd1 << 47) - 64'sd1;
    localparam longint Q40_BOTTOM   = -(64'sd1 << 47);
    localparam longint TWO_PI_FIX   = 64'sh6487ED5110B;
    localparam longint UNIT_OUT     = 64'sd1 << 30;
    localparam logic [TOL_W-1:0] TOL_AT_RESET = 21'd1074;
    localparam logic [PADDR_W-1:0] TOL_ADDR    = {REG_SNAP_TOL, 2'b00};
    localparam logic [PADDR_W-1:0] UNUSED_ADDR = 3'd4;
    localparam int IDLE_LIMIT = 4000;
    localparam int NUM_PHASES = 5;
    localparam int PHASE_ITEMS = 106;
    localparam int NUM_ROWS = 21;

    // angles in q4.28
    localparam int HALF_PI_FIX  = 421657428;
    localparam int PI_FIX       = 843314857;
    localparam int THREE_HALF_PI = 1264972285;
    localparam int TWO_PI_ANGLE = 1686629713;

    typedef struct {
        logic               m;
        logic signed [31:0] a;
        logic               known;
        logic signed [31:0] v;
    } row_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       arg_valid = 1'b0;
    logic                       arg_ready;
    logic                       mode = MODE_SIN;
    logic signed [ANGLE_W-1:0]  angle = '0;
    logic                       res_valid;
    logic                       res_ready = 1'b0;
    logic signed [VALUE_W-1:0]  value;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [PADDR_W-1:0]         paddr = '0;
    logic [PDATA_W-1:0]         pwdata = '0;
    logic [PDATA_W-1:0]         prdata;
    logic                       pready;

    // typed-in expectation travelling with the item
    logic                       drv_known = 1'b0;
    logic signed [31:0]         drv_value = '0;

    logic [TOL_W-1:0]           tol_model = TOL_AT_RESET;
    logic signed [31:0]         value_q[$];
    logic signed [31:0]         want;
    int                         fails = 0;
    int                         reg_fails = 0;
    int                         idle_cycles = 0;
    int                         burst_left = 0;

    int                         ready_style = 0;
    int                         ready_left = 0;
    int                         stall_left = 0;

    row_t                       dir_rows [NUM_ROWS];

    sine_cosine_taylor_series_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .arg_valid (arg_valid),
        .arg_ready (arg_ready),
        .mode      (mode),
        .angle     (angle),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .value     (value),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic longint q40_clamp(input longint v);
        if (v > Q40_TOP)
            return Q40_TOP;
        if (v < Q40_BOTTOM)
            return Q40_BOTTOM;
        return v;
    endfunction

    // product truncated toward zero, magnitude capped at 2^47 before the sign
    function automatic longint q40_mul(input longint a, input longint b);
        logic [63:0]  ma;
        logic [63:0]  mb;
        logic [127:0] p;
        logic [63:0]  m;
        longint       r;
        ma = (a < 0) ? 64'(-a) : 64'(a);
        mb = (b < 0) ? 64'(-b) : 64'(b);
        p = {64'd0, ma} * {64'd0, mb};
        m = p[103:40];
        if (m > (64'd1 << 47))
            m = 64'd1 << 47;
        r = longint'(m);
        if ((a < 0) != (b < 0))
            r = -r;
        return q40_clamp(r);
    endfunction

    function automatic logic signed [31:0] taylor_value(input logic m,
                                                        input logic signed [31:0] a,
                                                        input logic [TOL_W-1:0] tol);
        longint x;
        longint y;
        longint acc;
        longint sum;
        longint s;
        longint mag;
        longint dist_one;
        longint d;
        longint res;
        int     n;
        x = longint'(a) * 4096;
        if (x >= TWO_PI_FIX)
            x = x - TWO_PI_FIX;
        else if (x <= -TWO_PI_FIX)
            x = x + TWO_PI_FIX;
        y = q40_mul(x, x);
        acc = Q40_UNIT;
        for (n = TERMS - 1; n >= 1; n--)
        begin
            if (m == MODE_SIN)
                d = longint'(2 * n) * longint'(2 * n + 1);
            else
                d = longint'(2 * n - 1) * longint'(2 * n);
            acc = q40_clamp(Q40_UNIT - q40_mul(y, acc) / d);
        end
        sum = (m == MODE_SIN) ? q40_mul(x, acc) : acc;
        s = (sum < 0) ? -((-sum) >>> 10) : (sum >>> 10);
        mag = (s < 0) ? -s : s;
        if (mag < longint'(tol))
            res = 0;
        else
        begin
            dist_one = UNIT_OUT - mag;
            if (dist_one < 0)
                dist_one = -dist_one;
            if (dist_one < longint'(tol))
                res = (s < 0) ? -UNIT_OUT : UNIT_OUT;
            else if (s > UNIT_OUT)
                res = UNIT_OUT;
            else if (s < -UNIT_OUT)
                res = -UNIT_OUT;
            else
                res = s;
        end
        return res[31:0];
    endfunction

    function automatic logic signed [31:0] pick_angle();
        int     sel;
        longint k;
        longint off;
        sel = $urandom_range(0, 19);
        if (sel < 10)
            return $urandom;
        if (sel < 16)
        begin
            // close to a multiple of pi/2, where the snapping happens
            k = longint'($urandom_range(0, 10)) - 5;
            off = longint'($urandom_range(0, 4000)) - 2000;
            return 32'(k * HALF_PI_FIX + off);
        end
        if (sel < 19)
            return 32'(longint'($urandom_range(0, 8191)) - 4096);
        case ($urandom_range(0, 5))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return TWO_PI_ANGLE;
            3: return TWO_PI_ANGLE + 1;
            4: return -TWO_PI_ANGLE;
            default: return -TWO_PI_ANGLE - 1;
        endcase
    endfunction

    // receiver: changes its stall style every so often
    always @(posedge clk)
    begin
        if (ready_left == 0)
        begin
            ready_style <= $urandom_range(0, 3);
            ready_left <= $urandom_range(20, 120);
        end
        else
            ready_left <= ready_left - 1;
        case (ready_style)
            0: res_ready <= 1'b1;
            1: res_ready <= 1'($urandom_range(0, 1));
            2: res_ready <= ($urandom_range(0, 9) != 0);
            default:
            begin
                if (stall_left != 0)
                begin
                    res_ready <= 1'b0;
                    stall_left <= stall_left - 1;
                end
                else
                begin
                    res_ready <= 1'b1;
                    if ($urandom_range(0, 15) == 0)
                        stall_left <= $urandom_range(5, 30);
                end
            end
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (arg_valid && arg_ready)
                value_q.push_back(drv_known ? drv_value : taylor_value(mode, angle, tol_model));
            if (res_valid && res_ready)
            begin
                if (value_q.size() == 0)
                begin
                    $error("value: no item waiting, got %0d", value);
                    fails++;
                end
                else
                begin
                    want = value_q.pop_front();
                    if (value !== want)
                    begin
                        $error("value: expected %0d, got %0d", want, value);
                        fails++;
                    end
                end
            end
            if ((arg_valid && arg_ready) || (res_valid && res_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_arg(input logic m, input logic signed [31:0] a,
                            input logic known, input logic signed [31:0] v);
        int gap;
        if (burst_left == 0)
        begin
            arg_valid <= 1'b0;
            gap = $urandom_range(1, 10);
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                      : $urandom_range(1, 24);
        end
        arg_valid <= 1'b1;
        mode <= m;
        angle <= a;
        drv_known <= known;
        drv_value <= v;
        @(posedge clk);
        while (!arg_ready)
            @(posedge clk);
        burst_left--;
    endtask

    // hold the sender until every item in flight has come out
    task automatic wait_results();
        arg_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (value_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic reg_access(input logic wr, input logic [PADDR_W-1:0] addr,
                              input logic [PDATA_W-1:0] wdata,
                              output logic [PDATA_W-1:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_tolerance();
        logic [PDATA_W-1:0] got;
        reg_access(1'b0, TOL_ADDR, '0, got);
        if (got !== PDATA_W'(tol_model))
        begin
            $error("snap_tolerance: expected %0d, got %0d", tol_model, got);
            reg_fails++;
        end
    endtask

    initial
    begin
        logic [PDATA_W-1:0] tol_words [NUM_PHASES];
        logic [PDATA_W-1:0] dummy;
        int                 ph;
        int                 i;
        int                 r;

        dir_rows = '{
            '{MODE_SIN, 32'sd0, 1'b1, 32'sd0},
            '{MODE_COS, 32'sd0, 1'b1, 32'sd1073741824},
            '{MODE_SIN, 32'sd1, 1'b1, 32'sd0},
            '{MODE_COS, 32'sd1, 1'b1, 32'sd1073741824},
            '{MODE_SIN, -32'sd1, 1'b1, 32'sd0},
            '{MODE_COS, -32'sd1, 1'b1, 32'sd1073741824},
            '{MODE_SIN, 32'sh7FFFFFFF, 1'b0, 32'sd0},
            '{MODE_COS, 32'sh7FFFFFFF, 1'b0, 32'sd0},
            '{MODE_SIN, 32'sh80000000, 1'b0, 32'sd0},
            '{MODE_COS, 32'sh80000000, 1'b0, 32'sd0},
            '{MODE_SIN, HALF_PI_FIX, 1'b0, 32'sd0},
            '{MODE_COS, HALF_PI_FIX, 1'b0, 32'sd0},
            '{MODE_SIN, -HALF_PI_FIX, 1'b0, 32'sd0},
            '{MODE_COS, PI_FIX, 1'b0, 32'sd0},
            '{MODE_SIN, PI_FIX, 1'b0, 32'sd0},
            '{MODE_SIN, THREE_HALF_PI, 1'b0, 32'sd0},
            '{MODE_SIN, TWO_PI_ANGLE, 1'b0, 32'sd0},
            '{MODE_COS, TWO_PI_ANGLE, 1'b0, 32'sd0},
            '{MODE_SIN, TWO_PI_ANGLE + 1, 1'b0, 32'sd0},
            '{MODE_SIN, -TWO_PI_ANGLE, 1'b0, 32'sd0},
            '{MODE_COS, -TWO_PI_ANGLE - 1, 1'b0, 32'sd0}
        };
        tol_words[0] = 32'd0;
        tol_words[1] = 32'h001FFFFF;
        tol_words[2] = 32'd1048576;
        // upper bits beyond the register width must be dropped
        tol_words[3] = 32'hABE00000 | $urandom_range(0, 2097151);
        tol_words[4] = $urandom_range(0, 4000);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        check_tolerance();

        for (r = 0; r < NUM_ROWS; r++)
            send_arg(dir_rows[r].m, dir_rows[r].a, dir_rows[r].known, dir_rows[r].v);
        wait_results();

        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            reg_access(1'b1, TOL_ADDR, tol_words[ph], dummy);
            tol_model = tol_words[ph][TOL_W-1:0];
            if (ph == 2)
                reg_access(1'b1, UNUSED_ADDR, $urandom, dummy);
            check_tolerance();
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                send_arg(1'($urandom_range(0, 1)), pick_angle(), 1'b0, 32'sd0);
                if (ph == 1 && i == 50)
                    wait_results();
            end
            wait_results();
        end

        repeat (100) @(posedge clk);
        if (fails == 0 && reg_fails == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
